// File: rtl/tcaof_pkg.sv
`default_nettype none
package tcaof_pkg;

  // operation codes of the input item
  localparam logic [1:0] FN_ENQ     = 2'd0;
  localparam logic [1:0] FN_DEQ_ANY = 2'd1;
  localparam logic [1:0] FN_DEQ_0   = 2'd2;
  localparam logic [1:0] FN_DEQ_1   = 2'd3;

  // class codes
  localparam logic [1:0] CLS_0 = 2'd0;
  localparam logic [1:0] CLS_1 = 2'd1;

  // result status codes
  localparam logic [2:0] ST_ENQ     = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DEQ     = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // command to one queue
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  // status of one queue
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// File: rtl/tcaof_cell.sv
`default_nettype none
module tcaof_cell #(
  parameter int TAG_BITS   = 16,
  parameter int STAMP_BITS = 32
) (
  input  wire                      clk,
  input  wire tcaof_pkg::cell_ctl_t ctl,
  input  wire     [TAG_BITS-1:0]   load_tag,
  input  wire     [STAMP_BITS-1:0] load_stamp,
  input  wire     [TAG_BITS-1:0]   next_tag,
  input  wire     [STAMP_BITS-1:0] next_stamp,
  output logic    [TAG_BITS-1:0]   tag,
  output logic    [STAMP_BITS-1:0] stamp
);

  logic [TAG_BITS-1:0]   tag_r;
  logic [STAMP_BITS-1:0] stamp_r;

  // new item at the tail wins, else move one place toward the head
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tag_r   <= load_tag;
      stamp_r <= load_stamp;
    end else if (ctl.shift) begin
      tag_r   <= next_tag;
      stamp_r <= next_stamp;
    end
  end

  assign tag   = tag_r;
  assign stamp = stamp_r;

endmodule
`default_nettype wire

// File: rtl/tcaof_queue.sv
`default_nettype none
module tcaof_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  parameter int STAMP_BITS  = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire tcaof_pkg::q_cmd_t   cmd,
  input  wire     [TAG_BITS-1:0]   push_tag,
  input  wire     [STAMP_BITS-1:0] push_stamp,
  output tcaof_pkg::q_stat_t       stat,
  output logic    [TAG_BITS-1:0]   head_tag,
  output logic    [STAMP_BITS-1:0] head_stamp
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  // index QUEUE_DEPTH is the feed behind the last cell
  logic [TAG_BITS-1:0]   tag_w   [QUEUE_DEPTH+1];
  logic [STAMP_BITS-1:0] stamp_w [QUEUE_DEPTH+1];

  assign tag_w[QUEUE_DEPTH]   = push_tag;
  assign stamp_w[QUEUE_DEPTH] = push_stamp;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tcaof_pkg::cell_ctl_t ctl;

    // the tail cell is the one at the fill position
    assign ctl.load  = cmd.push && (fill_r == FILL_W'(i));
    assign ctl.shift = cmd.pop;

    tcaof_cell #(
      .TAG_BITS   (TAG_BITS),
      .STAMP_BITS (STAMP_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_tag   (push_tag),
      .load_stamp (push_stamp),
      .next_tag   (tag_w[i+1]),
      .next_stamp (stamp_w[i+1]),
      .tag        (tag_w[i]),
      .stamp      (stamp_w[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign head_tag   = tag_w[0];
  assign head_stamp = stamp_w[0];

endmodule
`default_nettype wire

// File: rtl/two_class_age_ordered_fifo.sv
// the result of an accepted item is in the output register in the cycle after it is taken
// throughput: one item per cycle while the result side takes every result
// each queue is a row of shift cells with the head in cell 0, so a pop is one shift
// reset (synchronous, rst_n low) empties both queues, clears the arrival counter
// and drops any pending result; cell contents are left as they are
`default_nettype none
module two_class_age_ordered_fifo #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  parameter int STAMP_BITS  = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [1:0]            in_func,
  input  wire  [1:0]            in_item_class,
  input  wire  [TAG_BITS-1:0]   in_item_tag,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            out_status,
  output logic [TAG_BITS-1:0]   out_tag,
  output logic                  out_class,
  output logic [STAMP_BITS-1:0] out_stamp
);

  // ---------------------------------------------------------------
  // handshake: one result register; a new item enters whenever that
  // register is free or is being emptied in the same cycle
  // ---------------------------------------------------------------
  logic take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // running arrival stamp, advanced by every accepted enqueue
  logic [STAMP_BITS-1:0] counter_r;
  logic [STAMP_BITS-1:0] counter_nxt;

  // the two queues
  tcaof_pkg::q_cmd_t  cmd0, cmd1;
  tcaof_pkg::q_stat_t stat0, stat1;
  logic [TAG_BITS-1:0]   head_tag0, head_tag1;
  logic [STAMP_BITS-1:0] head_stamp0, head_stamp1;

  tcaof_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_queue0 (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd0),
    .push_tag   (in_item_tag),
    .push_stamp (counter_r),
    .stat       (stat0),
    .head_tag   (head_tag0),
    .head_stamp (head_stamp0)
  );

  tcaof_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_queue1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd1),
    .push_tag   (in_item_tag),
    .push_stamp (counter_r),
    .stat       (stat1),
    .head_tag   (head_tag1),
    .head_stamp (head_stamp1)
  );

  // ---------------------------------------------------------------
  // age compare of the two heads: class 0 is older only when the
  // modular difference is negative, so a tie goes to class 1
  // ---------------------------------------------------------------
  logic [STAMP_BITS-1:0] stamp_diff;
  logic                  head0_older;

  assign stamp_diff  = head_stamp0 - head_stamp1;
  assign head0_older = stamp_diff[STAMP_BITS-1];

  // ---------------------------------------------------------------
  // decode of the item
  // ---------------------------------------------------------------
  logic pop0, pop1;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic                  class_r, class_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;

  always_comb begin
    cmd0        = '0;
    cmd1        = '0;
    pop0        = 1'b0;
    pop1        = 1'b0;
    counter_nxt = counter_r;
    status_nxt  = tcaof_pkg::ST_EMPTY;
    tag_nxt     = '0;
    class_nxt   = 1'b0;
    stamp_nxt   = '0;

    if (take) begin
      case (in_func)
        tcaof_pkg::FN_ENQ: begin
          // the stamp is used up even when the item is dropped
          counter_nxt = counter_r + STAMP_BITS'(1);
          if (in_item_class == tcaof_pkg::CLS_0) begin
            if (stat0.full) begin
              status_nxt = tcaof_pkg::ST_FULL;
            end else begin
              cmd0.push  = 1'b1;
              status_nxt = tcaof_pkg::ST_ENQ;
            end
          end else if (in_item_class == tcaof_pkg::CLS_1) begin
            if (stat1.full) begin
              status_nxt = tcaof_pkg::ST_FULL;
            end else begin
              cmd1.push  = 1'b1;
              status_nxt = tcaof_pkg::ST_ENQ;
            end
          end else begin
            status_nxt = tcaof_pkg::ST_UNKNOWN;
          end
        end
        tcaof_pkg::FN_DEQ_0: begin
          pop0 = !stat0.empty;
        end
        tcaof_pkg::FN_DEQ_1: begin
          pop1 = !stat1.empty;
        end
        tcaof_pkg::FN_DEQ_ANY: begin
          // both heads present: the older one goes; one side empty: take the other head
          if (!stat0.empty && !stat1.empty) begin
            pop0 = head0_older;
            pop1 = !head0_older;
          end else begin
            pop0 = !stat0.empty;
            pop1 = !stat1.empty;
          end
        end
        default: begin
          status_nxt = tcaof_pkg::ST_EMPTY;
        end
      endcase

      if (pop0) begin
        cmd0.pop   = 1'b1;
        status_nxt = tcaof_pkg::ST_DEQ;
        tag_nxt    = head_tag0;
        class_nxt  = 1'b0;
        stamp_nxt  = head_stamp0;
      end else if (pop1) begin
        cmd1.pop   = 1'b1;
        status_nxt = tcaof_pkg::ST_DEQ;
        tag_nxt    = head_tag1;
        class_nxt  = 1'b1;
        stamp_nxt  = head_stamp1;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      counter_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      counter_r   <= counter_nxt;
    end
  end

  // payload only loads with a new item
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status_nxt;
      tag_r    <= tag_nxt;
      class_r  <= class_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_tag    = tag_r;
  assign out_class  = class_r;
  assign out_stamp  = stamp_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd0.pop && cmd1.pop))
    else $error("both queues popped for one item");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !((cmd0.push || cmd1.push) && (cmd0.pop || cmd1.pop)))
    else $error("push and pop for one item");

  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_func == tcaof_pkg::FN_ENQ) |=>
      counter_r == $past(counter_r) + STAMP_BITS'(1))
    else $error("arrival counter did not advance on enqueue");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while result register is held");

endmodule
`default_nettype wire

// File: verif/two_class_age_ordered_fifo_tb.sv
module two_class_age_ordered_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int TAG_W          = 16;
  localparam int STAMP_W        = 32;
  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_AFTER     = 40;    // accepted items before the long receiver hold
  localparam int HOLD_CYCLES    = 120;   // long enough to back the block up completely
  localparam int WATCHDOG_LIMIT = 1000;  // idle cycles, well past the longest legal stall
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 6;

  // class codes the block must reject
  localparam logic [1:0] CLS_UNK_LO = 2'd2;
  localparam logic [1:0] CLS_UNK_HI = 2'd3;

  // one input item, plus a flag that makes the sender wait for a drained pipe first
  typedef struct {
    logic [1:0]       func;
    logic [1:0]       cls;
    logic [TAG_W-1:0] tag;
    bit               sync;
  } shelter_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [TAG_W-1:0]   tag;
    logic               cls;
    logic [STAMP_W-1:0] stamp;
  } shelter_resp_t;

  // one queued resident: its tag and its arrival stamp
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } resident_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = '0;
  logic [1:0]         in_item_class = '0;
  logic [TAG_W-1:0]   in_item_tag = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [TAG_W-1:0]   out_tag;
  logic               out_class;
  logic [STAMP_W-1:0] out_stamp;

  // items still to be offered, and results the block still owes us
  shelter_req_t  pending_reqs[$];
  shelter_resp_t awaited_resps[$];

  // predictor state: both class queues and the running arrival stamp
  resident_t        kennel0[$];
  resident_t        kennel1[$];
  logic [STAMP_W-1:0] arrival_count = '0;

  int fail_count  = 0;
  int taken_items = 0;
  int idle_cycles = 0;
  bit in_taken    = 1'b0;

  // sender burst / gap bookkeeping
  int burst_left = 8;
  int gap_left   = 0;

  // receiver stall pattern and the one long hold
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int run_left   = 0;
  bit run_ready  = 1'b1;

  two_class_age_ordered_fifo #(
    .QUEUE_DEPTH(DEPTH),
    .TAG_BITS   (TAG_W),
    .STAMP_BITS (STAMP_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_item_class(in_item_class),
    .in_item_tag  (in_item_tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_tag      (out_tag),
    .out_class    (out_class),
    .out_stamp    (out_stamp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // works out the result of one accepted item and updates the predicted queues
  function shelter_resp_t next_outcome(input logic [1:0] func, input logic [1:0] cls,
                                       input logic [TAG_W-1:0] tag);
    shelter_resp_t      r;
    resident_t          who;
    logic [STAMP_W-1:0] age_gap;
    bit                 use0;
    bit                 use1;
    r = '0;
    r.status = tcaof_pkg::ST_EMPTY;
    use0 = 1'b0;
    use1 = 1'b0;
    if (func == tcaof_pkg::FN_ENQ) begin
      // the stamp advances on every enqueue, stored or dropped
      who.tag = tag;
      who.stamp = arrival_count;
      arrival_count = arrival_count + 1'b1;
      if (cls == tcaof_pkg::CLS_0) begin
        if (kennel0.size() < DEPTH) begin
          kennel0.push_back(who);
          r.status = tcaof_pkg::ST_ENQ;
        end else begin
          r.status = tcaof_pkg::ST_FULL;
        end
      end else if (cls == tcaof_pkg::CLS_1) begin
        if (kennel1.size() < DEPTH) begin
          kennel1.push_back(who);
          r.status = tcaof_pkg::ST_ENQ;
        end else begin
          r.status = tcaof_pkg::ST_FULL;
        end
      end else begin
        r.status = tcaof_pkg::ST_UNKNOWN;
      end
    end else begin
      if (func == tcaof_pkg::FN_DEQ_0) begin
        use0 = kennel0.size() != 0;
      end else if (func == tcaof_pkg::FN_DEQ_1) begin
        use1 = kennel1.size() != 0;
      end else if (kennel0.size() == 0) begin
        use1 = kennel1.size() != 0;
      end else if (kennel1.size() == 0) begin
        use0 = 1'b1;
      end else begin
        // class 0 wins only when its head is strictly older; a tie goes to class 1
        age_gap = kennel0[0].stamp - kennel1[0].stamp;
        use0 = age_gap[STAMP_W-1];
        use1 = !use0;
      end
      if (use0) begin
        who = kennel0.pop_front();
        r.status = tcaof_pkg::ST_DEQ;
        r.tag = who.tag;
        r.cls = 1'b0;
        r.stamp = who.stamp;
      end else if (use1) begin
        who = kennel1.pop_front();
        r.status = tcaof_pkg::ST_DEQ;
        r.tag = who.tag;
        r.cls = 1'b1;
        r.stamp = who.stamp;
      end
    end
    return r;
  endfunction

  task report_mismatch(input string what, input shelter_resp_t want,
                       input shelter_resp_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t %s: expected status %0d tag %h class %0d stamp %h,",
               $realtime, what, want.status, want.tag, want.cls, want.stamp,
               " got status %0d tag %h class %0d stamp %h",
               got.status, got.tag, got.cls, got.stamp);
  endtask

  task add_req(input logic [1:0] func, input logic [1:0] cls, input logic [TAG_W-1:0] tag,
               input bit sync);
    shelter_req_t req;
    req.func = func;
    req.cls = cls;
    req.tag = tag;
    req.sync = sync;
    pending_reqs.push_back(req);
  endtask

  // monitor: checks results, predicts accepted items, runs the watchdog
  always @(posedge clk) begin
    shelter_resp_t got;
    shelter_resp_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      // results are checked before this edge's input is predicted; an item
      // accepted now cannot have its result on the same edge
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.tag = out_tag;
        got.cls = out_class;
        got.stamp = out_stamp;
        if (awaited_resps.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got);
        end else begin
          want = awaited_resps.pop_front();
          if (got.status !== want.status || got.tag !== want.tag ||
              got.cls !== want.cls || got.stamp !== want.stamp)
            report_mismatch("result mismatch", want, got);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        awaited_resps.push_back(next_outcome(in_func, in_item_class, in_item_tag));
        taken_items++;
      end
      // watchdog: any handshake on either side counts as progress
      if (in_taken || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // sender: bursts of items with random gaps, fed from pending_reqs
  always @(negedge clk) begin
    shelter_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].sync && awaited_resps.size() != 0)) begin
        // a sync item is held back until every owed result has come out
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_func <= req.func;
        in_item_class <= req.cls;
        in_item_tag <= req.tag;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          // some bursts run straight into the next one with no gap
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: its own ready pattern, plus one long hold that backs up the block
  always @(negedge clk) begin
    int pick;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && taken_items >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // long stretch with no stall at all
          run_ready = 1'b1;
          run_left = $urandom_range(30, 60);
        end else if (pick < 6) begin
          run_ready = 1'b1;
          run_left = $urandom_range(1, 8);
        end else begin
          run_ready = 1'b0;
          run_left = $urandom_range(1, 4);
        end
      end
      run_left--;
      out_ready <= run_ready;
    end
  end

  initial begin
    int          enq_pct;
    int          cls_bias;
    int          pick;
    logic [1:0]  func;
    logic [1:0]  cls;

    // directed: every dequeue on an empty block
    add_req(tcaof_pkg::FN_DEQ_ANY, tcaof_pkg::CLS_0, 16'h0000, 1'b0);
    add_req(tcaof_pkg::FN_DEQ_0, tcaof_pkg::CLS_1, 16'hffff, 1'b0);
    add_req(tcaof_pkg::FN_DEQ_1, CLS_UNK_HI, 16'h1234, 1'b0);
    // both unknown class codes, still advancing the stamp
    add_req(tcaof_pkg::FN_ENQ, CLS_UNK_LO, 16'hffff, 1'b0);
    add_req(tcaof_pkg::FN_ENQ, CLS_UNK_HI, 16'h0000, 1'b0);
    // one class 1 item, older than everything in class 0
    add_req(tcaof_pkg::FN_ENQ, tcaof_pkg::CLS_1, 16'hffff, 1'b0);
    // fill class 0 and push one past full
    for (int k = 0; k <= DEPTH; k++)
      add_req(tcaof_pkg::FN_ENQ, tcaof_pkg::CLS_0,
              (k == 0) ? 16'h0000 : (k == 1) ? 16'hffff : 16'($urandom), 1'b0);
    // oldest-first picks class 1, then only class 0 is left
    add_req(tcaof_pkg::FN_DEQ_ANY, tcaof_pkg::CLS_0, 16'h0000, 1'b0);
    add_req(tcaof_pkg::FN_DEQ_ANY, tcaof_pkg::CLS_1, 16'hffff, 1'b0);

    // random: phases of varying enqueue / dequeue mix and class skew, so both
    // queues run full and run dry many times over
    enq_pct = 50;
    cls_bias = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        enq_pct = $urandom_range(25, 85);
        cls_bias = $urandom_range(0, 100);
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        func = tcaof_pkg::FN_ENQ;
        pick = $urandom_range(0, 19);
        if (pick == 0)
          cls = CLS_UNK_LO;
        else if (pick == 1)
          cls = CLS_UNK_HI;
        else
          cls = ($urandom_range(0, 99) < cls_bias) ? tcaof_pkg::CLS_1 : tcaof_pkg::CLS_0;
      end else begin
        pick = $urandom_range(0, 2);
        case (pick)
          0: begin
            func = tcaof_pkg::FN_DEQ_ANY;
          end
          1: begin
            func = tcaof_pkg::FN_DEQ_0;
          end
          default: begin
            func = tcaof_pkg::FN_DEQ_1;
          end
        endcase
        cls = 2'($urandom_range(0, 3));
      end
      // a few points where the sender waits for the block to drain
      add_req(func, cls, 16'($urandom), (i == 0) || (i == 200) || (i == 330));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // settle past the edge so the monitor and sender have both run
    do begin
      @(posedge clk);
      #0.5;
    end while (pending_reqs.size() != 0 || in_valid || awaited_resps.size() != 0);

    // extra cycles to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    #0.5;
    if (awaited_resps.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", awaited_resps.size());
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
